// ===== rtl/core/delayed_periodic_timer_defines.svh =====
// ----------------------------------------------------------------------------
// Delayed periodic timer assertion macros
// Property wrappers shared by the timer's checks, clocked on clk and
// disabled while arst_n is low.
// ----------------------------------------------------------------------------
`ifndef DELAYED_PERIODIC_TIMER_DEFINES_SVH
`define DELAYED_PERIODIC_TIMER_DEFINES_SVH

// same-cycle implication
`define DPT_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define DPT_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/dpt_pkg.sv =====
// ----------------------------------------------------------------------------
// Delayed periodic timer package
// Tick width, compare width, register indexes and shared types.
// ----------------------------------------------------------------------------
package dpt_pkg;

	localparam int TICK_WIDTH = 32;
	localparam int REG_WIDTH  = 32;
	localparam int CMP_WIDTH  = (TICK_WIDTH > REG_WIDTH) ? TICK_WIDTH : REG_WIDTH;
	localparam int PROD_WIDTH = 2 * REG_WIDTH;
	localparam int CFG_IDX_W  = 2;

	typedef logic [TICK_WIDTH-1:0] tick_t;
	typedef logic [CMP_WIDTH-1:0]  cmp_t;
	typedef logic [REG_WIDTH-1:0]  reg_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

	localparam cfg_idx_t CFG_FIRST_DELAY  = 2'd0;
	localparam cfg_idx_t CFG_PERIOD       = 2'd1;
	localparam cfg_idx_t CFG_REPEAT_LIMIT = 2'd2;

endpackage

// ===== rtl/core/delayed_periodic_timer.sv =====
// ----------------------------------------------------------------------------
// Delayed periodic timer
// One timer session with an initial delay, a period and a repeat limit,
// polled with a free-running tick.
// ----------------------------------------------------------------------------
// Usage:
//   item channel (item_valid / item_stall): action and now_tick. action 1
//   starts a session at now_tick, action 0 polls at now_tick.
//   result channel (result_valid / result_stall): fire, finished and
//   fires_so_far, exactly one word per item, in order.
//   cfg channel (cfg_valid / cfg_ready): cfg_index 0 first_delay, 1 period,
//   2 repeat_limit; index 3 is dropped. cfg_ready is always high.
// Throughput: one item per cycle while the result is not stalled and no step
// recompute is pending; the poll logic is one subtract, add and compare pass
// between the input register and the result register; a word goes through
// both before it shows on the result channel. A period write recomputes the
// scheduled step with one 32x32 multiplier; the input register waits for it.
// Reset: configuration and session state clear to zero, as if a session had
// started at tick 0; no word is pending.
// Stall: a stalled result holds; one more item is taken into the input
// register, then item_stall rises until the result is taken.
// ----------------------------------------------------------------------------
`include "delayed_periodic_timer_defines.svh"

module delayed_periodic_timer
	import dpt_pkg::*;
(
	input  logic            clk,
	input  logic            arst_n,
	input  logic            item_valid,
	output logic            item_stall,
	input  logic            action,
	input  logic [31:0]     now_tick,
	output logic            result_valid,
	input  logic            result_stall,
	output logic            fire,
	output logic            finished,
	output logic [31:0]     fires_so_far,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  cfg_idx_t        cfg_index,
	input  logic [31:0]     cfg_data
);

	reg_t  first_delay_q, period_q, repeat_limit_q;
	tick_t origin_q, last_lapse_q, step_q;
	reg_t  fired_count_q;
	logic  dirty_q;

	logic  valid_s1, action_s1;
	tick_t now_s1;

	logic  result_valid_q, fire_q, finished_q;
	reg_t  fires_q;

	logic  accept, advance, cfg_wr;
	logic  done_cur, done_new, in_delay, delay_ok, ready_ok, fire_new;
	tick_t delay_t, period_t, d0, d1, last_eff, base_tick;
	tick_t origin_n, last_lapse_n, step_n;
	reg_t  count_n, cnt_inc;
	logic [PROD_WIDTH-1:0] prod;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign advance   = valid_s1 && !dirty_q && (!result_valid_q || !result_stall);
	assign item_stall = valid_s1 && !advance;
	assign accept    = item_valid && !item_stall;

	assign delay_t  = TICK_WIDTH'(cmp_t'(first_delay_q));
	assign period_t = TICK_WIDTH'(cmp_t'(period_q));
	assign cnt_inc  = fired_count_q + reg_t'(1);
	assign prod     = {{REG_WIDTH{1'b0}}, cnt_inc} * {{REG_WIDTH{1'b0}}, period_q};

	always_comb begin
		done_cur  = !repeat_limit_q[REG_WIDTH-1] && (fired_count_q > repeat_limit_q);
		in_delay  = (last_lapse_q == origin_q);
		d0        = now_s1 - origin_q;
		delay_ok  = cmp_t'(d0) >= cmp_t'(first_delay_q);
		ready_ok  = !in_delay || delay_ok;
		base_tick = origin_q + delay_t;
		last_eff  = in_delay ? base_tick : last_lapse_q;
		d1        = now_s1 - last_eff;
		fire_new  = 1'b0;
		origin_n     = origin_q;
		last_lapse_n = last_lapse_q;
		step_n       = step_q;
		count_n      = fired_count_q;
		if (action_s1) begin
			origin_n     = now_s1;
			last_lapse_n = now_s1;
			step_n       = period_t;
			count_n      = '0;
		end else if (!done_cur) begin
			if (in_delay && delay_ok) begin
				last_lapse_n = base_tick;
			end
			if (ready_ok && (cmp_t'(d1) >= cmp_t'(period_q))) begin
				fire_new     = 1'b1;
				count_n      = cnt_inc;
				last_lapse_n = base_tick + step_q;
				step_n       = step_q + period_t;
			end
		end
		done_new = !repeat_limit_q[REG_WIDTH-1] && (count_n > repeat_limit_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_delay_q  <= '0;
			period_q       <= '0;
			repeat_limit_q <= '0;
			dirty_q        <= 1'b0;
		end else begin
			dirty_q <= 1'b0;
			if (cfg_wr) begin
				case (cfg_index)
					CFG_FIRST_DELAY:  first_delay_q  <= cfg_data;
					CFG_PERIOD: begin
						period_q <= cfg_data;
						dirty_q  <= 1'b1;
					end
					CFG_REPEAT_LIMIT: repeat_limit_q <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_q      <= '0;
			last_lapse_q  <= '0;
			step_q        <= '0;
			fired_count_q <= '0;
		end else if (dirty_q) begin
			step_q <= TICK_WIDTH'(prod);
		end else if (advance) begin
			origin_q      <= origin_n;
			last_lapse_q  <= last_lapse_n;
			step_q        <= step_n;
			fired_count_q <= count_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			action_s1 <= action;
			now_s1    <= TICK_WIDTH'(cmp_t'(now_tick));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			fire_q     <= fire_new;
			finished_q <= done_new;
			fires_q    <= count_n;
		end
	end

	assign result_valid = result_valid_q;
	assign fire         = fire_q;
	assign finished     = finished_q;
	assign fires_so_far = fires_q;

	`DPT_ASSERT_NOW(a_no_work_in_recompute, dirty_q, !advance,
		"item processed while step is recomputed")
	`DPT_ASSERT_NEXT(a_start_clears, advance && action_s1,
		result_valid && !fire && !finished && (fires_so_far == '0),
		"start word not cleared")
	`DPT_ASSERT_NEXT(a_finished_holds, advance && !action_s1 && done_cur,
		result_valid && !fire && finished && (fires_so_far == $past(fired_count_q)),
		"finished session changed")
	`DPT_ASSERT_NEXT(a_fire_counts, advance && fire_new,
		fires_so_far == $past(fired_count_q) + reg_t'(1),
		"fire did not advance count")

endmodule

// ===== tb/sv/tb_delayed_periodic_timer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Delayed periodic timer testbench
// Drives start and poll words with random ticks through several register
// settings and checks every result word against an in-bench model of the
// session: delay phase, periodic firing, repeat limit and tick wrap.
// ----------------------------------------------------------------------------
module tb_delayed_periodic_timer;
	import dpt_pkg::*;

	localparam logic     ACT_POLL   = 1'b0;
	localparam logic     ACT_START  = 1'b1;
	localparam cfg_idx_t CFG_UNUSED = 2'd3;
	localparam int       HOLD_LEN   = 60;

	typedef struct packed {
		logic  act;
		tick_t now;
	} timer_item_t;

	typedef struct packed {
		logic  fire;
		logic  finished;
		reg_t  count;
	} timer_word_t;

	logic     clk          = 1'b0;
	logic     arst_n       = 1'b0;
	logic     item_valid   = 1'b0;
	logic     item_stall;
	logic     action       = 1'b0;
	logic     [31:0] now_tick = '0;
	logic     result_valid;
	logic     result_stall = 1'b0;
	logic     fire;
	logic     finished;
	logic     [31:0] fires_so_far;
	logic     cfg_valid    = 1'b0;
	logic     cfg_ready;
	cfg_idx_t cfg_index    = CFG_FIRST_DELAY;
	logic     [31:0] cfg_data = '0;

	timer_item_t pending_items[$];
	timer_word_t expected_words[$];
	int          mismatches = 0;
	bit          calm       = 1'b0;
	bit          want_hold  = 1'b0;
	bit          hold_taken = 1'b0;
	int          hold_left  = 0;

	// model copy of the session and its registers
	reg_t  cfg_delay  = '0;
	reg_t  cfg_period = '0;
	reg_t  cfg_limit  = '0;
	tick_t sess_origin = '0;
	tick_t sess_lapse  = '0;
	reg_t  sess_fires  = '0;

	delayed_periodic_timer dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.action       (action),
		.now_tick     (now_tick),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.fire         (fire),
		.finished     (finished),
		.fires_so_far (fires_so_far),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic logic session_over();
		return !cfg_limit[31] && (sess_fires > cfg_limit);
	endfunction

	function automatic timer_word_t predict_timer(logic act, tick_t now);
		timer_word_t w;
		logic go;
		w.fire = 1'b0;
		if (act == ACT_START) begin
			sess_origin = now;
			sess_lapse  = now;
			sess_fires  = '0;
		end else if (!session_over()) begin
			go = 1'b1;
			if (sess_lapse == sess_origin) begin
				if (tick_t'(now - sess_origin) >= cfg_delay)
					sess_lapse = sess_origin + cfg_delay;
				else
					go = 1'b0;
			end
			if (go && tick_t'(now - sess_lapse) >= cfg_period) begin
				w.fire     = 1'b1;
				sess_fires = sess_fires + 1;
				sess_lapse = sess_origin + cfg_delay + sess_fires * cfg_period;
			end
		end
		w.finished = session_over();
		w.count    = sess_fires;
		return w;
	endfunction

	// driver: predict on acceptance, then offer the next word or idle
	always @(posedge clk) begin
		timer_item_t it;
		timer_word_t exp_w;
		if (item_valid && !item_stall) begin
			exp_w = predict_timer(action, now_tick);
			expected_words = {expected_words, exp_w};
		end
		if (!item_valid || !item_stall) begin
			if (arst_n && pending_items.size() > 0 && (calm || $urandom_range(0, 99) >= 24)) begin
				it = pending_items.pop_front();
				item_valid <= 1'b1;
				action     <= it.act;
				now_tick   <= it.now;
			end else begin
				item_valid <= 1'b0;
			end
		end
	end

	// receiver: random stalls, one long hold-off on request
	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left    <= hold_left - 1;
			result_stall <= 1'b1;
		end else if (want_hold && !hold_taken) begin
			hold_taken   <= 1'b1;
			hold_left    <= HOLD_LEN;
			result_stall <= 1'b1;
		end else begin
			result_stall <= !calm && ($urandom_range(0, 99) < 24);
		end
	end

	// monitor
	always @(posedge clk) begin
		timer_word_t w;
		if (arst_n && result_valid && !result_stall) begin
			if (expected_words.size() == 0) begin
				$error("result word with no expectation pending");
				mismatches++;
			end else begin
				w = expected_words.pop_front();
				if (w.fire !== fire) begin
					$error("fire: expected %0d, got %0d", w.fire, fire);
					mismatches++;
				end
				if (w.finished !== finished) begin
					$error("finished: expected %0d, got %0d", w.finished, finished);
					mismatches++;
				end
				if (w.count !== fires_so_far) begin
					$error("fires_so_far: expected %0d, got %0d", w.count, fires_so_far);
					mismatches++;
				end
			end
		end
	end

	task automatic push_item(logic act, tick_t now);
		timer_item_t it;
		it.act = act;
		it.now = now;
		pending_items = {pending_items, it};
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_items.size() != 0 || item_valid || expected_words.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(cfg_idx_t idx, reg_t value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			CFG_FIRST_DELAY:  cfg_delay  = value;
			CFG_PERIOD:       cfg_period = value;
			CFG_REPEAT_LIMIT: cfg_limit  = value;
			default: ;
		endcase
	endtask

	task automatic set_timer(reg_t delay, reg_t per, reg_t limit);
		wait_drained();
		cfg_write(CFG_FIRST_DELAY, delay);
		cfg_write(CFG_PERIOD, per);
		cfg_write(CFG_REPEAT_LIMIT, limit);
		@(negedge clk);
	endtask

	// mostly well-formed sessions, some noise and backward ticks
	task automatic fill_random(int n);
		int left;
		int r;
		tick_t t;
		reg_t big;
		reg_t span;
		logic [32:0] s;
		left = n;
		t    = $urandom();
		big  = (cfg_delay > cfg_period) ? cfg_delay : cfg_period;
		s    = {1'b0, big} + (big >> 2) + 3;
		span = s[32] ? '1 : s[31:0];
		while (left > 0) begin
			r = $urandom_range(0, 99);
			if (r < 80) begin
				if ($urandom_range(0, 3) == 0)
					t = $urandom();
				push_item(ACT_START, t);
				left--;
				repeat ($urandom_range(2, 12)) begin
					t = t + $urandom_range(0, span);
					push_item(ACT_POLL, t);
					left--;
				end
			end else if (r < 90) begin
				t = $urandom();
				push_item(logic'($urandom_range(0, 1)), t);
				left--;
			end else begin
				t = t - $urandom_range(1, span);
				push_item(ACT_POLL, t);
				left--;
			end
		end
	endtask

	task automatic run_phase(reg_t delay, reg_t per, reg_t limit, int n, bit quiet, bit hold);
		set_timer(delay, per, limit);
		calm      = quiet;
		want_hold = hold;
		fill_random(n / 2);
		wait_drained();
		@(negedge clk);
		fill_random(n - n / 2);
		wait_drained();
		@(negedge clk);
		calm = 1'b0;
	endtask

	initial begin
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: zero delay, zero period, one fire allowed
		push_item(ACT_POLL, 32'h0000_0000);
		push_item(ACT_POLL, 32'hFFFF_FFFF);
		push_item(ACT_START, 32'hFFFF_FFFF);
		push_item(ACT_POLL, 32'hFFFF_FFFF);
		push_item(ACT_POLL, 32'h0000_0000);

		// widest delay and period, unlimited; index 3 is dropped
		set_timer(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		cfg_write(CFG_UNUSED, $urandom());
		@(negedge clk);
		push_item(ACT_START, 32'h0000_0000);
		push_item(ACT_POLL, 32'h0000_0001);
		push_item(ACT_POLL, 32'hFFFF_FFFF);
		push_item(ACT_POLL, 32'hFFFF_FFFF);
		push_item(ACT_POLL, 32'hFFFF_FFFE);

		// delay plus period wraps onto the origin: back into the delay phase
		set_timer(32'hFFFF_FF00, 32'h0000_0100, 32'd3);
		push_item(ACT_START, 32'h0000_0010);
		push_item(ACT_POLL, 32'hFFFF_FF10);
		push_item(ACT_POLL, 32'h0000_0010);
		push_item(ACT_POLL, 32'h0000_0020);
		push_item(ACT_POLL, 32'hFFFF_FF10);
		push_item(ACT_POLL, 32'h0000_0010);
		push_item(ACT_POLL, 32'h0000_0010);

		// zero period, unlimited: fire on every poll
		set_timer(32'd0, 32'd0, 32'hFFFF_FFFF);
		push_item(ACT_START, 32'h0000_0005);
		push_item(ACT_POLL, 32'h0000_0005);
		push_item(ACT_POLL, 32'h0000_0005);
		push_item(ACT_POLL, 32'h0000_0004);
		push_item(ACT_POLL, 32'h0000_0000);

		// largest positive limit
		set_timer(32'd3, 32'd2, 32'h7FFF_FFFF);
		push_item(ACT_START, 32'h0000_0000);
		push_item(ACT_POLL, 32'h0000_0002);
		push_item(ACT_POLL, 32'h0000_0003);
		push_item(ACT_POLL, 32'h0000_0005);
		push_item(ACT_POLL, 32'h0000_0007);

		run_phase($urandom_range(0, 40), $urandom_range(0, 25),
			$urandom_range(0, 7) - 1, 75, 1'b1, 1'b0);
		run_phase($urandom_range(0, 40), $urandom_range(0, 25),
			$urandom_range(0, 7) - 1, 75, 1'b0, 1'b1);
		run_phase(32'd0, 32'd0, $urandom_range(0, 7) - 1, 75, 1'b0, 1'b0);
		run_phase($urandom_range(0, 40), $urandom_range(1, 25), 32'h7FFF_FFFF, 75, 1'b0, 1'b0);
		run_phase($urandom(), $urandom(), 32'hFFFF_FFFF, 75, 1'b0, 1'b0);
		run_phase($urandom_range(0, 40), $urandom_range(0, 25),
			$urandom_range(0, 7) - 1, 75, 1'b0, 1'b0);

		wait_drained();
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#3_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
